FILE: rtl/core/led_strip_effect_frame_generator_defines.svh
// Assertion macros used by the checker file.
// Depends on nothing; included by bare file name.
`ifndef LED_STRIP_EFFECT_FRAME_GENERATOR_DEFINES_SVH
`define LED_STRIP_EFFECT_FRAME_GENERATOR_DEFINES_SVH

// Clocked assertion, disabled while reset is active.
`define LSEFG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define LSEFG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/lsefg_pkg.sv
// Package for the LED strip effect frame generator: widths, constants, codes.
// Used by the channel interfaces, the top level and the checker.
package lsefg_pkg;

  localparam int NumPixels  = 12;
  localparam int PixW       = 4;
  localparam int PosW       = 5;
  localparam int ModeW      = 3;
  localparam int ChanW      = 8;
  localparam int SolidW     = 32;
  localparam int EffectW    = 24;
  localparam int TickW      = 10;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 32;

  localparam int WaveLen    = 2 * NumPixels;
  localparam int TailLen    = 8;
  localparam int CometLen   = NumPixels + TailLen;
  localparam int WaveStep   = 40;
  localparam int TailShift  = 5;
  localparam int PulseStep  = 5;
  localparam int PulseTop   = 250;
  localparam int PulseFloor = 5;
  localparam int LevelMax   = 255;
  localparam int IntervalRst = 50;

  typedef enum logic [ModeW-1:0] {
    MODE_OFF   = 3'd0,
    MODE_SOLID = 3'd1,
    MODE_PULSE = 3'd2,
    MODE_WAVE  = 3'd3,
    MODE_COMET = 3'd4
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE     = 2'd0,
    REG_SOLID    = 2'd1,
    REG_EFFECT   = 2'd2,
    REG_INTERVAL = 2'd3
  } cfg_reg_e;

endpackage

FILE: rtl/core/lsefg_if.sv
// Valid/ready channel interfaces: millisecond ticks, pixel results, config writes.
// Depends on lsefg_pkg.
interface lsefg_tick_if import lsefg_pkg::*; ();
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface lsefg_pix_if import lsefg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PixW-1:0]  pixel_index;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;
  logic [ChanW-1:0] white;
  logic             frame_end;

  modport source (output valid, output pixel_index, output red, output green,
                  output blue, output white, output frame_end, input ready);
  modport sink   (input valid, input pixel_index, input red, input green,
                  input blue, input white, input frame_end, output ready);
endinterface

interface lsefg_cfg_if import lsefg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/led_strip_effect_frame_generator.sv
// LED strip effect frame generator.
// tick_i carries one beat per millisecond; restart=1 clears the animation
// state and the frame timer and produces nothing. An ordinary tick advances
// the timer; when it reaches frame_interval the animation steps once and a
// frame of NumPixels (12) RGBW beats leaves on pix_o, pixel 0 first, with
// frame_end on the last pixel.
// cfg_i writes mode, solid_color, effect_color and frame_interval by index;
// it is always ready; the user must see that it is written only while no
// frame is in flight, as the block itself does not enforce this. A frame tick
// sets the busy state register, and pixel 0 then reaches pix_o through the
// output register; with pix_o.ready high the pixels follow one per cycle from
// the single pixel shader. tick_i takes a beat every cycle except while the
// frame's pixels are still being shaded, which lasts longer if pix_o stalls.
// A stalled receiver holds the output register; shading pauses behind it.
// Reset initialises all state except the output beat data; frame_interval is 50.
// Depends on lsefg_pkg and lsefg_if.
module led_strip_effect_frame_generator import lsefg_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  lsefg_tick_if.sink   tick_i,
  lsefg_cfg_if.sink    cfg_i,
  lsefg_pix_if.source  pix_o
);

  // configuration
  logic [ModeW-1:0]   mode_q;
  logic [SolidW-1:0]  solid_q;
  logic [EffectW-1:0] effect_q;
  logic [TickW-1:0]   interval_q;

  // animation state
  logic [TickW-1:0]   tick_q, tick_d;
  logic [ChanW-1:0]   plvl_q, plvl_d;
  logic               prise_q, prise_d;
  logic [PosW-1:0]    wpos_q, wpos_d;
  logic [PosW-1:0]    cpos_q, cpos_d;

  // frame emission
  logic               busy_q, busy_d;
  logic [PixW-1:0]    pix_q, pix_d;
  logic               ovalid_q, ovalid_d;
  logic [PixW-1:0]    oidx_q;
  logic [ChanW-1:0]   ored_q, ogrn_q, oblu_q, owht_q;
  logic               oend_q;

  logic               tick_acc;
  logic               load_out;
  logic               pix_last;
  logic [TickW-1:0]   tick_inc;
  logic               frame_hit;

  // pixel shader
  logic [ChanW-1:0]   level;
  logic [PosW-1:0]    pix_ext;
  logic [PosW-1:0]    wdist;
  logic [PosW-1:0]    wfold;
  logic [TickW-1:0]   wdrop;
  logic [PosW-1:0]    cdist;
  logic [ChanW-1:0]   sh_r, sh_g, sh_b, sh_w;

  function automatic logic [ChanW-1:0] scale_chan(input logic [ChanW-1:0] c,
                                                   input logic [ChanW-1:0] l);
    logic [2*ChanW-1:0] prod;
    logic [2*ChanW:0]   sum;
    begin
      prod = c * l;
      // exact floor(prod / 255) for any product of two 8-bit values
      sum  = {1'b0, prod} + {9'd0, prod[2*ChanW-1:ChanW]} + 17'd1;
      return sum[2*ChanW-1:ChanW];
    end
  endfunction

  assign tick_i.ready = ~busy_q;
  assign cfg_i.ready  = 1'b1;
  assign tick_acc     = tick_i.valid & ~busy_q;
  assign load_out     = busy_q & (~ovalid_q | pix_o.ready);
  assign pix_last     = (pix_q == PixW'(NumPixels - 1));
  assign tick_inc     = tick_q + TickW'(1);
  assign frame_hit    = (tick_inc >= interval_q);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_OFF;
      solid_q    <= '0;
      effect_q   <= '0;
      interval_q <= TickW'(IntervalRst);
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_MODE:     mode_q     <= cfg_i.data[ModeW-1:0];
        REG_SOLID:    solid_q    <= cfg_i.data[SolidW-1:0];
        REG_EFFECT:   effect_q   <= cfg_i.data[EffectW-1:0];
        REG_INTERVAL: interval_q <= cfg_i.data[TickW-1:0];
        default:      ;
      endcase
    end
  end

  // tick handling, animation step and pixel advance
  always_comb begin
    tick_d  = tick_q;
    plvl_d  = plvl_q;
    prise_d = prise_q;
    wpos_d  = wpos_q;
    cpos_d  = cpos_q;
    busy_d  = busy_q;
    pix_d   = pix_q;
    if (tick_acc) begin
      if (tick_i.restart) begin
        tick_d  = '0;
        plvl_d  = '0;
        prise_d = 1'b1;
        wpos_d  = '0;
        cpos_d  = '0;
      end else if (frame_hit) begin
        tick_d = '0;
        busy_d = 1'b1;
        pix_d  = '0;
        unique case (mode_q)
          MODE_PULSE: begin
            if (prise_q) begin
              plvl_d = plvl_q + ChanW'(PulseStep);
              if (plvl_d >= ChanW'(PulseTop)) prise_d = 1'b0;
            end else begin
              plvl_d = plvl_q - ChanW'(PulseStep);
              if (plvl_d <= ChanW'(PulseFloor)) prise_d = 1'b1;
            end
          end
          MODE_WAVE: begin
            wpos_d = (wpos_q == PosW'(WaveLen - 1)) ? '0 : wpos_q + PosW'(1);
          end
          MODE_COMET: begin
            cpos_d = (cpos_q == PosW'(CometLen - 1)) ? '0 : cpos_q + PosW'(1);
          end
          default: ;
        endcase
      end else begin
        tick_d = tick_inc;
      end
    end else if (load_out) begin
      pix_d = pix_q + PixW'(1);
      if (pix_last) busy_d = 1'b0;
    end
  end

  // level of the pixel being shaded
  always_comb begin
    pix_ext = {1'b0, pix_q};
    wdist   = (wpos_q >= pix_ext) ? (wpos_q - pix_ext) : (pix_ext - wpos_q);
    wfold   = (wdist > PosW'(NumPixels)) ? (PosW'(WaveLen) - wdist) : wdist;
    wdrop   = TickW'(wfold) * TickW'(WaveStep);
    cdist   = cpos_q - pix_ext;
    unique case (mode_q)
      MODE_PULSE: level = plvl_q;
      MODE_WAVE:  level = (wdrop >= TickW'(LevelMax)) ? '0
                        : ChanW'(TickW'(LevelMax) - wdrop);
      MODE_COMET: level = (cpos_q >= pix_ext && cdist < PosW'(TailLen))
                        ? ChanW'(LevelMax) - {cdist[2:0], {TailShift{1'b0}}}
                        : '0;
      default:    level = '0;
    endcase
  end

  always_comb begin
    sh_r = '0;
    sh_g = '0;
    sh_b = '0;
    sh_w = '0;
    unique case (mode_q)
      MODE_SOLID: begin
        sh_r = solid_q[31:24];
        sh_g = solid_q[23:16];
        sh_b = solid_q[15:8];
        sh_w = solid_q[7:0];
      end
      MODE_PULSE, MODE_WAVE, MODE_COMET: begin
        sh_r = scale_chan(effect_q[23:16], level);
        sh_g = scale_chan(effect_q[15:8], level);
        sh_b = scale_chan(effect_q[7:0], level);
      end
      default: ;
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (load_out)         ovalid_d = 1'b1;
    else if (pix_o.ready) ovalid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q   <= '0;
      plvl_q   <= '0;
      prise_q  <= 1'b1;
      wpos_q   <= '0;
      cpos_q   <= '0;
      busy_q   <= 1'b0;
      pix_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      tick_q   <= tick_d;
      plvl_q   <= plvl_d;
      prise_q  <= prise_d;
      wpos_q   <= wpos_d;
      cpos_q   <= cpos_d;
      busy_q   <= busy_d;
      pix_q    <= pix_d;
      ovalid_q <= ovalid_d;
    end
  end

  // output beat register; hold while stalled
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      oidx_q <= pix_q;
      ored_q <= sh_r;
      ogrn_q <= sh_g;
      oblu_q <= sh_b;
      owht_q <= sh_w;
      oend_q <= pix_last;
    end
  end

  assign pix_o.valid       = ovalid_q;
  assign pix_o.pixel_index = oidx_q;
  assign pix_o.red         = ored_q;
  assign pix_o.green       = ogrn_q;
  assign pix_o.blue        = oblu_q;
  assign pix_o.white       = owht_q;
  assign pix_o.frame_end   = oend_q;

endmodule

FILE: rtl/core/lsefg_checker.sv
// Port-level checker for the LED strip effect frame generator, with its bind.
// Depends on lsefg_pkg and led_strip_effect_frame_generator_defines.svh.
`include "led_strip_effect_frame_generator_defines.svh"

module lsefg_checker import lsefg_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             tick_ready_i,
  input logic             pix_valid_i,
  input logic             pix_ready_i,
  input logic [PixW-1:0]  pix_index_i,
  input logic [ChanW-1:0] pix_red_i,
  input logic [ChanW-1:0] pix_white_i,
  input logic             pix_end_i
);

  // a stalled beat holds
  `LSEFG_ASSERT(a_pix_hold, clk_i, rst_ni, pix_valid_i && !pix_ready_i |=> pix_valid_i && $stable(pix_index_i) && $stable(pix_red_i) && $stable(pix_white_i) && $stable(pix_end_i), "stalled pixel beat changed")

  // frame_end marks exactly the last pixel
  `LSEFG_ASSERT(a_end_last, clk_i, rst_ni, pix_valid_i |-> (pix_end_i == (pix_index_i == PixW'(NumPixels - 1))), "frame_end not on last pixel")

  // pixels of a frame follow without gaps
  `LSEFG_ASSERT(a_pix_seq, clk_i, rst_ni, pix_valid_i && pix_ready_i && !pix_end_i |=> pix_valid_i && (pix_index_i == PixW'($past(pix_index_i) + PixW'(1))), "pixel sequence broken")

  // no new tick while the frame's pixels are still being produced
  `LSEFG_ASSERT(a_tick_block, clk_i, rst_ni, pix_valid_i && !pix_end_i |-> !tick_ready_i, "tick taken mid-frame")

endmodule

bind led_strip_effect_frame_generator lsefg_checker u_lsefg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .tick_ready_i (tick_i.ready),
  .pix_valid_i  (pix_o.valid),
  .pix_ready_i  (pix_o.ready),
  .pix_index_i  (pix_o.pixel_index),
  .pix_red_i    (pix_o.red),
  .pix_white_i  (pix_o.white),
  .pix_end_i    (pix_o.frame_end)
);
